[rtl/core/y2nv_pkg.sv]
// Shared types and constants for the YUYV to NV21 converter.
// No dependencies; every other file of the block imports this package.
package y2nv_pkg;

    localparam int ADDR_W  = 25;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 13;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;
    localparam int IN_DW   = 32;
    localparam int OUT_DW  = 40;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 13'd480;

    // Register index codes, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified macropixel, ready for the write sequencer
    typedef struct packed {
        logic [BYTE_W-1:0] y0;
        logic [BYTE_W-1:0] u;
        logic [BYTE_W-1:0] y1;
        logic [BYTE_W-1:0] v;
        logic [ADDR_W-1:0] luma_addr;
        logic [ADDR_W-1:0] chroma_addr;
        logic              even_row;
        logic              end_frame;
    } t_cmd;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Write sequencer steps
    typedef enum logic [3:0] {
        ST_Y0 = 4'b0001,
        ST_Y1 = 4'b0010,
        ST_V  = 4'b0100,
        ST_U  = 4'b1000
    } t_step;

endpackage

[rtl/core/yuyv_to_nv21_converter_top.sv]
// YUYV 4:2:2 to NV21 converter: front classifier, command queue, write sequencer.
// Accepted items pass through the queue, the command register and the output beat register.
// Each item is four byte writes on even rows and two on odd rows, one per byte-wide beat;
// input is taken every cycle while the queue has room and no restart is pending.
// Reset: synchronous active low; registers return to 640 x 480 and input stalls
// after reset and after each register write while the chroma base loads.
module yuyv_to_nv21_converter_top #(
    parameter int MAX_WIDTH  = y2nv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = y2nv_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [y2nv_pkg::APB_AW-1:0]   paddr,
    input  logic [y2nv_pkg::APB_DW-1:0]   pwdata,
    output logic [y2nv_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] luma_first, [15:8] chroma_blue, [23:16] luma_second, [31:24] chroma_red
    input  logic [y2nv_pkg::IN_DW-1:0]    s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [24:0] write_address, [32:25] write_byte, [39:33] zero
    output logic [y2nv_pkg::OUT_DW-1:0]   m_axis_tdata,
    // last_of_item
    output logic                          m_axis_tlast,
    // frame_done
    output logic                          m_axis_tuser
);
    import y2nv_pkg::*;

    logic    push;
    logic    pop;
    t_cmd    push_cmd;
    t_cmd    head_cmd;
    t_q_stat q_stat;

    // Classify items and generate addresses
    y2nv_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_push        (push),
        .o_cmd         (push_cmd),
        .i_q_stat      (q_stat)
    );

    // Buffer classified commands
    y2nv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    // Issue byte writes
    y2nv_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (head_cmd),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[rtl/core/y2nv_queue.sv]
// Short command queue that decouples the classifier from the write sequencer.
// Depends on y2nv_pkg for the command type and depth.
module y2nv_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  y2nv_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output y2nv_pkg::t_cmd    o_cmd,
    output y2nv_pkg::t_q_stat o_stat
);
    import y2nv_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

[rtl/core/y2nv_front.sv]
// Front end: configuration registers, raster counters and address generation.
// Classifies each accepted macropixel into a queue command; uses y2nv_pkg.
module y2nv_front #(
    parameter int MAX_WIDTH  = y2nv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = y2nv_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [y2nv_pkg::APB_AW-1:0]   paddr,
    input  logic [y2nv_pkg::APB_DW-1:0]   pwdata,
    output logic [y2nv_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] luma_first, [15:8] chroma_blue, [23:16] luma_second, [31:24] chroma_red
    input  logic [y2nv_pkg::IN_DW-1:0]    s_axis_tdata,
    output logic                          o_push,
    output y2nv_pkg::t_cmd                o_cmd,
    input  y2nv_pkg::t_q_stat             i_q_stat
);
    import y2nv_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int PW    = WW - 1;
    localparam int CW    = (MAX_WIDTH > 3) ? $clog2(MAX_WIDTH / 2) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int EXT_W = CFG_W + 1;

    logic [CFG_W-1:0]  r_width;
    logic [CFG_W-1:0]  r_height;
    logic              r_restart;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [ADDR_W-1:0] r_luma;
    logic [ADDR_W-1:0] r_chroma;

    logic [EXT_W-1:0]  w_ext;
    logic [EXT_W-1:0]  h_ext;
    logic [WW-1:0]     eff_w;
    logic [HW-1:0]     eff_h;
    logic [PW-1:0]     pairs;
    logic [WW+HW-1:0]  plane_prod;
    logic [ADDR_W-1:0] plane_base;
    logic [PW-1:0]     col_next;
    logic [HW-1:0]     row_next;
    logic              end_row;
    logic              end_frame;
    logic              even_row;
    logic              accept;
    logic              cfg_wr;

    // Clamp the width to an even value in range
    always_comb begin
        w_ext = {1'b0, r_width};
        if (w_ext > EXT_W'(MAX_WIDTH)) begin
            w_ext = EXT_W'(MAX_WIDTH);
        end
        eff_w = WW'(w_ext) & ~WW'(1);
        if (eff_w < WW'(2)) begin
            eff_w = WW'(2);
        end
    end

    // Clamp the height to at least one row and at most MAX_HEIGHT
    always_comb begin
        h_ext = {1'b0, r_height};
        if (h_ext > EXT_W'(MAX_HEIGHT)) begin
            h_ext = EXT_W'(MAX_HEIGHT);
        end
        eff_h = HW'(h_ext);
        if (eff_h < HW'(1)) begin
            eff_h = HW'(1);
        end
    end

    // Chroma plane base is width times height
    assign plane_prod = WW'(eff_w) * HW'(eff_h);
    assign plane_base = ADDR_W'(plane_prod);

    // Row and frame boundaries
    assign pairs     = eff_w[WW-1:1];
    assign col_next  = PW'(r_col) + PW'(1);
    assign row_next  = HW'(r_row) + HW'(1);
    assign end_row   = (col_next >= pairs);
    assign end_frame = end_row && (row_next >= eff_h);
    assign even_row  = ~r_row[0];

    assign s_axis_tready = !r_restart && !i_q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_wr        = psel && penable && pwrite && pready;

    // Register file, counters and running addresses
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= RST_WIDTH;
            r_height  <= RST_HEIGHT;
            r_restart <= 1'b1;
            r_col     <= '0;
            r_row     <= '0;
            r_luma    <= '0;
            r_chroma  <= '0;
        end else begin
            if (r_restart) begin
                r_restart <= 1'b0;
                r_col     <= '0;
                r_row     <= '0;
                r_luma    <= '0;
                r_chroma  <= plane_base;
            end else if (accept) begin
                if (end_frame) begin
                    r_col    <= '0;
                    r_row    <= '0;
                    r_luma   <= '0;
                    r_chroma <= plane_base;
                end else begin
                    r_luma <= r_luma + ADDR_W'(2);
                    if (even_row) begin
                        r_chroma <= r_chroma + ADDR_W'(2);
                    end
                    if (end_row) begin
                        r_col <= '0;
                        r_row <= r_row + RW'(1);
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end
            end
            // Any register write restarts the frame
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_WIDTH:  r_width  <= pwdata[CFG_W-1:0];
                    REG_HEIGHT: r_height <= pwdata[CFG_W-1:0];
                    default:    r_width  <= r_width;
                endcase
                r_restart <= 1'b1;
            end
        end
    end

    // Register readback
    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = APB_DW'(r_width);
            REG_HEIGHT: prdata = APB_DW'(r_height);
            default:    prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // Build the queue command
    assign o_push            = accept;
    assign o_cmd.y0          = s_axis_tdata[7:0];
    assign o_cmd.u           = s_axis_tdata[15:8];
    assign o_cmd.y1          = s_axis_tdata[23:16];
    assign o_cmd.v           = s_axis_tdata[31:24];
    assign o_cmd.luma_addr   = r_luma;
    assign o_cmd.chroma_addr = r_chroma;
    assign o_cmd.even_row    = even_row;
    assign o_cmd.end_frame   = end_frame;

endmodule

[rtl/core/y2nv_back.sv]
// Back end: sequences the two or four byte writes of each queued macropixel
// through a registered output beat; uses y2nv_pkg.
module y2nv_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  y2nv_pkg::t_cmd               i_cmd,
    input  y2nv_pkg::t_q_stat            i_q_stat,
    output logic                         o_pop,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [24:0] write_address, [32:25] write_byte, [39:33] zero
    output logic [y2nv_pkg::OUT_DW-1:0]  m_axis_tdata,
    // last_of_item
    output logic                         m_axis_tlast,
    // frame_done
    output logic                         m_axis_tuser
);
    import y2nv_pkg::*;

    t_cmd              r_cur;
    logic              r_busy;
    t_step             r_step;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic              r_out_done;

    t_step             n_step;
    logic [ADDR_W-1:0] step_addr;
    logic [BYTE_W-1:0] step_byte;
    logic              step_last;
    logic              step_done;
    logic              last_step;
    logic              out_load;
    logic              cur_done;

    // Decode the current write
    always_comb begin
        unique case (r_step)
            ST_Y0: begin
                step_addr = r_cur.luma_addr;
                step_byte = r_cur.y0;
                step_last = 1'b0;
                step_done = 1'b0;
                n_step    = ST_Y1;
            end
            ST_Y1: begin
                step_addr = r_cur.luma_addr + ADDR_W'(1);
                step_byte = r_cur.y1;
                step_last = !r_cur.even_row;
                step_done = !r_cur.even_row && r_cur.end_frame;
                n_step    = ST_V;
            end
            ST_V: begin
                step_addr = r_cur.chroma_addr;
                step_byte = r_cur.v;
                step_last = 1'b0;
                step_done = 1'b0;
                n_step    = ST_U;
            end
            ST_U: begin
                step_addr = r_cur.chroma_addr + ADDR_W'(1);
                step_byte = r_cur.u;
                step_last = 1'b1;
                step_done = r_cur.end_frame;
                n_step    = ST_Y0;
            end
            default: begin
                step_addr = '0;
                step_byte = '0;
                step_last = 1'b0;
                step_done = 1'b0;
                n_step    = ST_Y0;
            end
        endcase
    end

    assign last_step = step_last;
    assign out_load  = r_busy && (!r_out_valid || m_axis_tready);
    assign cur_done  = out_load && last_step;
    assign o_pop     = !i_q_stat.empty && (!r_busy || cur_done);

    // Hold the current command and advance through its writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= ST_Y0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= ST_Y0;
            end else if (cur_done) begin
                r_busy <= 1'b0;
                r_step <= ST_Y0;
            end else if (out_load) begin
                r_step <= n_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_cmd;
        end
    end

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_addr <= step_addr;
            r_out_byte <= step_byte;
            r_out_last <= step_last;
            r_out_done <= step_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DW - ADDR_W - BYTE_W){1'b0}}, r_out_byte, r_out_addr};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_done;

`ifndef SYNTHESIS
    a_odd_row_two_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !r_cur.even_row |-> (r_step == ST_Y0 || r_step == ST_Y1))
        else $error("odd-row command reached a chroma write");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame end flagged on a write that does not end its item");

    a_item_end_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cur_done |=> r_step == ST_Y0)
        else $error("sequencer did not rewind after the last write of an item");
`endif

endmodule
